FILE: rtl/tefs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tefs_pkg: shared types and constants of the triangle edge fill scan unit
// Coordinate and register widths, register map and reset values.
// ----------------------------------------------------------------------------
package tefs_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int COORD_W  = 12;
   localparam int DIM_W    = 13;
   localparam int VERTEX_W = 2 * COORD_W;
   localparam int ADDR_W   = 24;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int EDGE_W   = PROD_W + 1;
   localparam int SIDE_W   = DIM_W - 2;
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;

   localparam logic [DIM_W-1:0]   MAX_DIM_VAL   = DIM_W'(MAX_DIM);
   localparam logic [DIM_W-1:0]   DIM_RESET     = DIM_W'(MAX_DIM);
   localparam logic [COORD_W-1:0] SCAN_RESET    = COORD_W'(MAX_DIM / 4);

   typedef logic [COORD_W-1:0]       coord_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef enum logic [2:0] {
      REG_VERTEX_A     = 3'd0,
      REG_VERTEX_B     = 3'd1,
      REG_VERTEX_C     = 3'd2,
      REG_IMAGE_WIDTH  = 3'd3,
      REG_IMAGE_HEIGHT = 3'd4,
      REG_SHORT_SIDE   = 3'd5
   } reg_index_type;

   // signed difference of two unsigned coordinates
   function automatic diff_type coord_diff(input coord_type a, input coord_type b);
      coord_diff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

endpackage
`default_nettype wire

FILE: rtl/triangle_edge_fill_scan_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_edge_fill_scan_unit: edge-function triangle fill over a scan window
// Walks the window [s, 3*s), s = min(short_side, 4096)/4, in x (outer) and y
// (inner), one pixel per request, and flags triangle-covered pixels within the clip.
// ----------------------------------------------------------------------------
// Each accepted request yields one result: pixel position, framebuffer address
// x*image_height+y, a paint flag (write 255) and a last flag on the window's
// final pixel. One request is accepted per clock while no result is stalled.
// The input register holds the scanned position; the result register after
// it takes the edge functions, coverage and clip tests and the address, all
// worked out in one pass. The whole pipeline holds while a result waits on
// rsp_ready. The user writes the vertex and image registers through the APB
// port only while the unit is idle; the block itself does not enforce this.
module triangle_edge_fill_scan_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [tefs_pkg::PADDR_W-1:0] paddr,
   input  wire logic [tefs_pkg::PDATA_W-1:0] pwdata,
   output logic      [tefs_pkg::PDATA_W-1:0] prdata,
   output logic                             pready,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_restart,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [tefs_pkg::COORD_W-1:0] rsp_pixel_x,
   output logic      [tefs_pkg::COORD_W-1:0] rsp_pixel_y,
   output logic      [tefs_pkg::ADDR_W-1:0]  rsp_pixel_address,
   output logic                             rsp_paint,
   output logic                             rsp_last
);

   localparam int CW = tefs_pkg::COORD_W;
   localparam int DW = tefs_pkg::DIM_W;
   localparam int VW = tefs_pkg::VERTEX_W;
   localparam int PW = tefs_pkg::PROD_W;
   localparam int EW = tefs_pkg::EDGE_W;
   localparam int SW = tefs_pkg::SIDE_W;
   localparam int AW = tefs_pkg::ADDR_W;
   localparam int MW = CW + DW;

   // configuration registers
   logic [VW-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff;
   logic [DW-1:0] image_width_ff, image_height_ff, short_side_ff;
   tefs_pkg::reg_index_type reg_sel;
   logic cfg_write;

   assign pready    = 1'b1;
   assign reg_sel   = tefs_pkg::reg_index_type'(paddr[4:2]);
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff     <= '0;
         vertex_b_ff     <= '0;
         vertex_c_ff     <= '0;
         image_width_ff  <= tefs_pkg::DIM_RESET;
         image_height_ff <= tefs_pkg::DIM_RESET;
         short_side_ff   <= tefs_pkg::DIM_RESET;
      end else if (cfg_write) begin
         case (reg_sel)
            tefs_pkg::REG_VERTEX_A:     vertex_a_ff     <= pwdata[VW-1:0];
            tefs_pkg::REG_VERTEX_B:     vertex_b_ff     <= pwdata[VW-1:0];
            tefs_pkg::REG_VERTEX_C:     vertex_c_ff     <= pwdata[VW-1:0];
            tefs_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[DW-1:0];
            tefs_pkg::REG_IMAGE_HEIGHT: image_height_ff <= pwdata[DW-1:0];
            tefs_pkg::REG_SHORT_SIDE:   short_side_ff   <= pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_sel)
         tefs_pkg::REG_VERTEX_A:     prdata = {{(32-VW){1'b0}}, vertex_a_ff};
         tefs_pkg::REG_VERTEX_B:     prdata = {{(32-VW){1'b0}}, vertex_b_ff};
         tefs_pkg::REG_VERTEX_C:     prdata = {{(32-VW){1'b0}}, vertex_c_ff};
         tefs_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-DW){1'b0}}, image_width_ff};
         tefs_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-DW){1'b0}}, image_height_ff};
         tefs_pkg::REG_SHORT_SIDE:   prdata = {{(32-DW){1'b0}}, short_side_ff};
         default:                    prdata = '0;
      endcase
   end

   // pipeline control
   logic advance, accept;
   logic s1_valid_ff, rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && advance;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // scan window and counters
   logic [DW-1:0] side_eff;
   logic [SW-1:0] win_start;
   logic [CW-1:0] win_s, win_e, win_e_m1;
   logic          win_empty;
   logic [CW-1:0] scan_column_ff, scan_column_in, scan_row_ff, scan_row_in;
   logic [CW-1:0] cur_x, cur_y;
   logic          cur_last, jump;

   always_comb begin
      side_eff  = (short_side_ff > tefs_pkg::MAX_DIM_VAL) ? tefs_pkg::MAX_DIM_VAL
                                                          : short_side_ff;
      win_start = side_eff[DW-1:2];
      win_s     = CW'(win_start);
      win_e     = CW'({win_start, 1'b0}) + win_s;
      win_e_m1  = win_e - CW'(1);
      win_empty = (win_start == '0);
      jump      = req_restart || (scan_column_ff < win_s) || (scan_column_ff >= win_e)
                  || (scan_row_ff < win_s) || (scan_row_ff >= win_e);
      if (win_empty) begin
         cur_x = '0;
         cur_y = '0;
      end else if (jump) begin
         cur_x = win_s;
         cur_y = win_s;
      end else begin
         cur_x = scan_column_ff;
         cur_y = scan_row_ff;
      end
      cur_last = win_empty || ((cur_x == win_e_m1) && (cur_y == win_e_m1));
      scan_column_in = cur_x;
      scan_row_in    = cur_y;
      if (!win_empty) begin
         if (cur_y == win_e_m1) begin
            scan_row_in    = win_s;
            scan_column_in = (cur_x == win_e_m1) ? win_s : cur_x + CW'(1);
         end else begin
            scan_row_in = cur_y + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_column_ff <= tefs_pkg::SCAN_RESET;
         scan_row_ff    <= tefs_pkg::SCAN_RESET;
      end else if (accept) begin
         scan_column_ff <= scan_column_in;
         scan_row_ff    <= scan_row_in;
      end
   end

   // input stage
   logic [CW-1:0] s1_x_ff, s1_y_ff;
   logic          s1_last_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff    <= cur_x;
         s1_y_ff    <= cur_y;
         s1_last_ff <= cur_last;
      end
   end

   // result stage: index 3 holds the winding terms
   tefs_pkg::coord_type  ax, ay, bx, by, cx, cy;
   tefs_pkg::prod_type   prod_l [4];
   tefs_pkg::prod_type   prod_r [4];
   logic signed [EW-1:0] edge_val [4];
   logic [3:0]           edge_neg, edge_zero;
   logic                 all_ge, all_le, covered, clip;
   logic [MW-1:0]        addr_prod;
   logic [MW:0]          addr_sum;
   logic [CW-1:0]        rsp_x_ff, rsp_y_ff;
   logic [AW-1:0]        rsp_addr_ff;
   logic                 rsp_paint_ff, rsp_last_ff;

   assign ax = vertex_a_ff[VW-1:CW];
   assign ay = vertex_a_ff[CW-1:0];
   assign bx = vertex_b_ff[VW-1:CW];
   assign by = vertex_b_ff[CW-1:0];
   assign cx = vertex_c_ff[VW-1:CW];
   assign cy = vertex_c_ff[CW-1:0];

   always_comb begin
      prod_l[0] = PW'(tefs_pkg::coord_diff(bx, ax)) * PW'(tefs_pkg::coord_diff(s1_y_ff, ay));
      prod_r[0] = PW'(tefs_pkg::coord_diff(by, ay)) * PW'(tefs_pkg::coord_diff(s1_x_ff, ax));
      prod_l[1] = PW'(tefs_pkg::coord_diff(cx, bx)) * PW'(tefs_pkg::coord_diff(s1_y_ff, by));
      prod_r[1] = PW'(tefs_pkg::coord_diff(cy, by)) * PW'(tefs_pkg::coord_diff(s1_x_ff, bx));
      prod_l[2] = PW'(tefs_pkg::coord_diff(ax, cx)) * PW'(tefs_pkg::coord_diff(s1_y_ff, cy));
      prod_r[2] = PW'(tefs_pkg::coord_diff(ay, cy)) * PW'(tefs_pkg::coord_diff(s1_x_ff, cx));
      prod_l[3] = PW'(tefs_pkg::coord_diff(bx, ax)) * PW'(tefs_pkg::coord_diff(cy, ay));
      prod_r[3] = PW'(tefs_pkg::coord_diff(by, ay)) * PW'(tefs_pkg::coord_diff(cx, ax));
      for (int i = 0; i < 4; i++) begin
         edge_val[i]  = EW'(prod_l[i]) - EW'(prod_r[i]);
         edge_neg[i]  = edge_val[i][EW-1];
         edge_zero[i] = (edge_val[i] == '0);
      end
      all_ge  = !edge_neg[0] && !edge_neg[1] && !edge_neg[2];
      all_le  = (edge_neg[0] || edge_zero[0]) && (edge_neg[1] || edge_zero[1])
                && (edge_neg[2] || edge_zero[2]);
      // winding above zero takes the >= test
      covered = (!edge_neg[3] && !edge_zero[3]) ? all_ge : all_le;
      clip    = (s1_x_ff != '0) && ({1'b0, s1_x_ff} < image_width_ff)
                && (s1_y_ff != '0) && ({1'b0, s1_y_ff} < image_height_ff);
      addr_prod = MW'(s1_x_ff) * MW'(image_height_ff);
      addr_sum  = {1'b0, addr_prod} + (MW + 1)'(s1_y_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_x_ff     <= s1_x_ff;
         rsp_y_ff     <= s1_y_ff;
         rsp_addr_ff  <= addr_sum[AW-1:0];
         rsp_paint_ff <= covered && clip;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_pixel_x       = rsp_x_ff;
   assign rsp_pixel_y       = rsp_y_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_paint         = rsp_paint_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: triangle edge fill scan unit
// Drives pixel requests and APB register writes into the unit, predicts every
// scanned pixel (position, framebuffer address, coverage and clip test, end of
// window) and compares the results in order while both handshake sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import tefs_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_REPORTS = 50;
   localparam logic [PADDR_W-1:0] SPARE_ADDR_LO = 5'd24;
   localparam logic [PADDR_W-1:0] SPARE_ADDR_HI = 5'd28;

   typedef struct {
      coord_type          x;
      coord_type          y;
      logic [ADDR_W-1:0]  address;
      logic               paint;
      logic               last;
   } pixel_result_type;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;
   logic                req_valid;
   logic                req_ready;
   logic                req_restart;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [COORD_W-1:0]  rsp_pixel_x;
   logic [COORD_W-1:0]  rsp_pixel_y;
   logic [ADDR_W-1:0]   rsp_pixel_address;
   logic                rsp_paint;
   logic                rsp_last;

   logic [VERTEX_W-1:0] vert_a;
   logic [VERTEX_W-1:0] vert_b;
   logic [VERTEX_W-1:0] vert_c;
   logic [DIM_W-1:0]    clip_width;
   logic [DIM_W-1:0]    clip_height;
   logic [DIM_W-1:0]    side_len;
   int                  scan_x;
   int                  scan_y;

   pixel_result_type    expected_pixels[$];
   int                  error_count;
   bit                  sender_steady;
   bit                  receiver_steady;
   bit                  hold_requested;

   triangle_edge_fill_scan_unit uut (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_paint         (rsp_paint),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_error(input string msg);
      if (error_count < MAX_REPORTS) $display("mismatch: %s", msg);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [PADDR_W-1:0] csr_address(input reg_index_type r);
      return {r, 2'b00};
   endfunction

   function automatic logic [VERTEX_W-1:0] pack_vertex(input int x, input int y);
      return {COORD_W'(x), COORD_W'(y)};
   endfunction

   function automatic longint edge_value(input longint px, input longint py,
                                         input logic [VERTEX_W-1:0] u,
                                         input logic [VERTEX_W-1:0] v);
      longint ux, uy, vx, vy;
      ux = longint'(u[23:12]);
      uy = longint'(u[11:0]);
      vx = longint'(v[23:12]);
      vy = longint'(v[11:0]);
      return (vx - ux) * (py - uy) - (vy - uy) * (px - ux);
   endfunction

   function automatic void reset_scan_state();
      vert_a      = '0;
      vert_b      = '0;
      vert_c      = '0;
      clip_width  = DIM_RESET;
      clip_height = DIM_RESET;
      side_len    = DIM_RESET;
      scan_x      = int'(SCAN_RESET);
      scan_y      = int'(SCAN_RESET);
   endfunction

   function automatic void predict_pixel(input logic restart);
      pixel_result_type r;
      int               side_eff, s, e;
      longint           winding, e0, e1, e2;
      bit               covered, inside_clip;
      side_eff = (int'(side_len) > MAX_DIM) ? MAX_DIM : int'(side_len);
      s = side_eff / 4;
      e = 3 * s;
      if (s == 0) begin
         scan_x    = 0;
         scan_y    = 0;
         r.x       = '0;
         r.y       = '0;
         r.address = '0;
         r.paint   = 1'b0;
         r.last    = 1'b1;
      end else begin
         if (restart || scan_x < s || scan_x >= e || scan_y < s || scan_y >= e) begin
            scan_x = s;
            scan_y = s;
         end
         winding = edge_value(longint'(vert_c[23:12]), longint'(vert_c[11:0]),
                              vert_a, vert_b);
         e0 = edge_value(longint'(scan_x), longint'(scan_y), vert_a, vert_b);
         e1 = edge_value(longint'(scan_x), longint'(scan_y), vert_b, vert_c);
         e2 = edge_value(longint'(scan_x), longint'(scan_y), vert_c, vert_a);
         if (winding > 0) covered = e0 >= 0 && e1 >= 0 && e2 >= 0;
         else covered = e0 <= 0 && e1 <= 0 && e2 <= 0;
         inside_clip = scan_x > 0 && scan_x < int'(clip_width) &&
                       scan_y > 0 && scan_y < int'(clip_height);
         r.x       = COORD_W'(scan_x);
         r.y       = COORD_W'(scan_y);
         r.address = ADDR_W'(longint'(scan_x) * longint'(clip_height) + longint'(scan_y));
         r.paint   = covered && inside_clip;
         r.last    = (scan_x == e - 1) && (scan_y == e - 1);
         scan_y++;
         if (scan_y >= e) begin
            scan_y = s;
            scan_x++;
            if (scan_x >= e) scan_x = s;
         end
      end
      expected_pixels.push_back(r);
   endfunction

   // setup and access phase; the register takes the value at the access edge
   task automatic write_register(input logic [PADDR_W-1:0] addr,
                                 input logic [PDATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (addr[4:2])
         REG_VERTEX_A:     vert_a      = value[VERTEX_W-1:0];
         REG_VERTEX_B:     vert_b      = value[VERTEX_W-1:0];
         REG_VERTEX_C:     vert_c      = value[VERTEX_W-1:0];
         REG_IMAGE_WIDTH:  clip_width  = value[DIM_W-1:0];
         REG_IMAGE_HEIGHT: clip_height = value[DIM_W-1:0];
         REG_SHORT_SIDE:   side_len    = value[DIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_scene(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
                            input logic [VERTEX_W-1:0] c, input int width,
                            input int height, input int side);
      write_register(csr_address(REG_VERTEX_A), PDATA_W'(a));
      write_register(csr_address(REG_VERTEX_B), PDATA_W'(b));
      write_register(csr_address(REG_VERTEX_C), PDATA_W'(c));
      write_register(csr_address(REG_IMAGE_WIDTH), width);
      write_register(csr_address(REG_IMAGE_HEIGHT), height);
      write_register(csr_address(REG_SHORT_SIDE), side);
   endtask

   task automatic send_pixel_request(input logic restart);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      predict_pixel(restart);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_reset_state();
      send_pixel_request(1'b0);
      send_pixel_request(1'b0);
      send_pixel_request(1'b1);
      wait_idle();
   endtask

   task automatic test_empty_window();
      write_register(csr_address(REG_SHORT_SIDE), 0);
      send_pixel_request(1'b0);
      send_pixel_request(1'b1);
      wait_idle();
      write_register(csr_address(REG_SHORT_SIDE), 3);
      send_pixel_request(1'b0);
      wait_idle();
   endtask

   task automatic test_oversized_side();
      write_register(csr_address(REG_SHORT_SIDE), 8191);
      send_pixel_request(1'b1);
      send_pixel_request(1'b0);
      wait_idle();
      write_register(csr_address(REG_SHORT_SIDE), 4097);
      send_pixel_request(1'b0);
      wait_idle();
   endtask

   task automatic test_small_window_wrap();
      set_scene(pack_vertex(1, 1), pack_vertex(3, 1), pack_vertex(1, 3), 4096, 4096, 4);
      send_pixel_request(1'b1);
      repeat (4) send_pixel_request(1'b0);
      wait_idle();
      // flip the winding
      write_register(csr_address(REG_VERTEX_B), PDATA_W'(pack_vertex(1, 3)));
      write_register(csr_address(REG_VERTEX_C), PDATA_W'(pack_vertex(3, 1)));
      repeat (2) send_pixel_request(1'b0);
      wait_idle();
   endtask

   task automatic test_clip_and_extremes();
      set_scene(24'hFFFFFF, 24'h000000, 24'hFFF000, 0, 0, 8);
      send_pixel_request(1'b1);
      send_pixel_request(1'b0);
      wait_idle();
      write_register(csr_address(REG_IMAGE_WIDTH), 8191);
      write_register(csr_address(REG_IMAGE_HEIGHT), 8191);
      write_register(csr_address(REG_VERTEX_C), 32'h0000_0FFF);
      send_pixel_request(1'b0);
      send_pixel_request(1'b0);
      wait_idle();
   endtask

   task automatic test_window_shrink();
      set_scene(pack_vertex(5, 5), pack_vertex(40, 12), pack_vertex(14, 38), 4096, 4096, 40);
      send_pixel_request(1'b1);
      repeat (2) send_pixel_request(1'b0);
      wait_idle();
      write_register(csr_address(REG_SHORT_SIDE), 36);
      send_pixel_request(1'b0);
      wait_idle();
      // upper bits beyond the field are dropped
      write_register(csr_address(REG_SHORT_SIDE), 32'hFFFF_E010);
      send_pixel_request(1'b0);
      wait_idle();
   endtask

   task automatic test_unmapped_registers();
      write_register(SPARE_ADDR_LO, 32'hFFFF_FFFF);
      write_register(SPARE_ADDR_HI, 32'hFFFF_FFFF);
      send_pixel_request(1'b0);
      send_pixel_request(1'b0);
      wait_idle();
   endtask

   task automatic test_output_stall();
      set_scene(pack_vertex(0, 0), pack_vertex(60, 2), pack_vertex(4, 60), 4096, 4096, 40);
      hold_requested  = 1'b1;
      sender_steady   = 1'b1;
      send_pixel_request(1'b1);
      repeat (39) send_pixel_request(1'b0);
      sender_steady   = 1'b0;
      wait_idle();
   endtask

   function automatic logic [VERTEX_W-1:0] random_vertex(input int span);
      if ($urandom_range(0, 4) == 0) return VERTEX_W'($urandom());
      return pack_vertex($urandom_range(0, span), $urandom_range(0, span));
   endfunction

   function automatic int random_dim(input int window_end);
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, window_end + 2);
      return $urandom_range(0, 8191);
   endfunction

   task automatic test_random_traffic();
      int sent, count, side, s, e, span, r;
      sent = 0;
      side = 16;
      while (sent < 360) begin
         r = $urandom_range(0, 99);
         // keep the side now and then so the scan carries over between phases
         if (r >= 30) begin
            r = $urandom_range(0, 99);
            if (r < 6) side = $urandom_range(0, 3);
            else if (r < 10) side = $urandom_range(4097, 8191);
            else if (r < 14) side = $urandom_range(65, 4096);
            else if (r < 74) side = $urandom_range(4, 24);
            else side = $urandom_range(25, 64);
         end
         s    = ((side > MAX_DIM) ? MAX_DIM : side) / 4;
         e    = 3 * s;
         span = (e + s + 2 > 4095) ? 4095 : e + s + 2;
         set_scene(random_vertex(span), random_vertex(span), random_vertex(span),
                   random_dim(e), random_dim(e), side);
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         count = (side >= 4 && side <= 64) ? $urandom_range(10, 60) : $urandom_range(4, 12);
         repeat (count) send_pixel_request($urandom_range(0, 19) == 0);
         sent += count;
         wait_idle();
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_requested) begin
            hold_requested = 1'b0;
            stall_left     = LONG_HOLD - 1;
            rsp_ready     <= 1'b0;
         end else if (!receiver_steady && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_error($sformatf("result x=%0d y=%0d with no pending request",
                                   rsp_pixel_x, rsp_pixel_y));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_x !== want.x)
               report_error($sformatf("pixel_x got %0d want %0d", rsp_pixel_x, want.x));
            if (rsp_pixel_y !== want.y)
               report_error($sformatf("pixel_y got %0d want %0d", rsp_pixel_y, want.y));
            if (rsp_pixel_address !== want.address)
               report_error($sformatf("pixel_address at (%0d,%0d) got %0h want %0h",
                                      want.x, want.y, rsp_pixel_address, want.address));
            if (rsp_paint !== want.paint)
               report_error($sformatf("paint at (%0d,%0d) got %0b want %0b",
                                      want.x, want.y, rsp_paint, want.paint));
            if (rsp_last !== want.last)
               report_error($sformatf("last at (%0d,%0d) got %0b want %0b",
                                      want.x, want.y, rsp_last, want.last));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("[triangle_edge_fill_scan_unit] ERROR");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_valid       = 1'b0;
      req_restart     = 1'b0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_requested  = 1'b0;
      error_count     = 0;
      reset_scan_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_empty_window();
      test_oversized_side();
      test_small_window_wrap();
      test_clip_and_extremes();
      test_window_shrink();
      test_unmapped_registers();
      test_output_stall();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("[triangle_edge_fill_scan_unit] OK");
      else
         $display("[triangle_edge_fill_scan_unit] ERROR");
      $finish;
   end

endmodule
